FILE: rtl/core/bitmap_page_allocator_core_assert.svh
// Assertion helpers for the page allocator core.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Checked only outside reset.
`define BPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/bpa_pkg.sv
package bpa_pkg;

   localparam int NUM_PAGES     = 4096;
   localparam int PAGE_SHIFT    = 12;
   localparam int MAP_WORD_BITS = 64;
   localparam int ADDR_BITS     = 48;

   localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WIDX_BITS = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIDX_BITS = $clog2(MAP_WORD_BITS);
   localparam int PAGE_BITS = $clog2(NUM_PAGES);

   // page / MAP_WORD_BITS via floor reciprocal, off by at most one
   localparam int DIV_SHIFT = PAGE_BITS + 1;
   localparam int DIV_RECIP = (1 << DIV_SHIFT) / MAP_WORD_BITS;
   localparam int PROD_BITS = PAGE_BITS + DIV_SHIFT;
   localparam int MUL_BITS  = PAGE_BITS + BIDX_BITS + 1;

   // in-range bits of the last map word
   localparam int LAST_BITS = NUM_PAGES - (MAP_WORDS - 1) * MAP_WORD_BITS;
   localparam logic [MAP_WORD_BITS-1:0] LAST_MASK =
      {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_BITS);

   localparam logic [ADDR_BITS-1:0] BASE_RESET = 48'h0000_8000_0000;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NONE_FREE    = 2'd1;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

   typedef struct packed {
      logic                     rd_en;
      logic                     wr_en;
      logic [WIDX_BITS-1:0]     idx;
      logic [MAP_WORD_BITS-1:0] wr_data;
   } map_req_type;

   // reset contents of a map word: all pages free, padding bits clear
   function automatic logic [MAP_WORD_BITS-1:0] word_fill(input logic [WIDX_BITS-1:0] idx);
      word_fill = (idx == WIDX_BITS'(MAP_WORDS - 1)) ? LAST_MASK : {MAP_WORD_BITS{1'b1}};
   endfunction

   function automatic logic [BIDX_BITS-1:0] ffs_word(input logic [MAP_WORD_BITS-1:0] v);
      logic [BIDX_BITS-1:0] pos;
      pos = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) pos = BIDX_BITS'(i);
      end
      ffs_word = pos;
   endfunction

   function automatic logic [WIDX_BITS-1:0] ffs_summary(input logic [MAP_WORDS-1:0] v);
      logic [WIDX_BITS-1:0] pos;
      pos = '0;
      for (int i = MAP_WORDS - 1; i >= 0; i--) begin
         if (v[i]) pos = WIDX_BITS'(i);
      end
      ffs_summary = pos;
   endfunction

endpackage

FILE: rtl/core/bpa_ram.sv
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bpa_map.sv
module bpa_map (
   input  logic                           clock,
   input  logic                           reset,
   input  bpa_pkg::map_req_type           req,
   output logic [bpa_pkg::MAP_WORD_BITS-1:0] word,
   output logic [bpa_pkg::MAP_WORDS-1:0]  summary
);
   import bpa_pkg::*;

   logic [MAP_WORDS-1:0]     valid_ff;
   logic [MAP_WORDS-1:0]     summary_ff;
   logic                     rd_valid_ff;
   logic [WIDX_BITS-1:0]     rd_idx_ff;
   logic [MAP_WORD_BITS-1:0] ram_q;

   bpa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.idx),
      .wr_data (req.wr_data),
      .rd_en   (req.rd_en),
      .rd_addr (req.idx),
      .rd_data (ram_q)
   );

   // unwritten words read as their reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         summary_ff <= '1;
      end else if (req.wr_en) begin
         valid_ff[req.idx]   <= 1'b1;
         summary_ff[req.idx] <= |req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_valid_ff <= valid_ff[req.idx];
         rd_idx_ff   <= req.idx;
      end
   end

   assign word    = rd_valid_ff ? ram_q : word_fill(rd_idx_ff);
   assign summary = summary_ff;

endmodule

FILE: rtl/core/bitmap_page_allocator_core.sv
// Bitmap page allocator: one free bit per page, lowest free page first.
//
// Request: drive req_kind (0 allocate, 1 free) and req_page_address with
// start high; the item is taken on a rising edge where busy is low.
// Result: rsp_valid is high for exactly one cycle with rsp_granted_address
// and rsp_status (0 ok, 1 no free page, 2 freed address out of range).
// The receiver cannot stall; every result must be taken in its cycle.
// Steps: allocate S_LOOK, S_MOD, S_ADDR; free S_SPLIT, S_READ, S_MOD; an
// allocate with nothing free or an out-of-range free answers from S_LOOK or
// S_SPLIT. busy drops in the result cycle, so the next item is taken only once
// the last result shows. The steps come from the single map RAM: read one word,
// modify and write back, plus one step to split the page number into word/bit
// before the read (free) or to form the address after the write (allocate).
// A per-word summary flop vector picks the word to search; a priority
// encode in the word picks the page.
// Config: csr_wr_en/csr_wr_data write base_address; write only while idle.
// Reset: synchronous, active high. All pages read as free immediately
// after reset (per-word valid bits, no clearing pass); base_address returns
// to 0x8000_0000.
`include "bitmap_page_allocator_core_assert.svh"

module bitmap_page_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [bpa_pkg::ADDR_BITS-1:0]  req_page_address,
   output logic                           rsp_valid,
   output logic [bpa_pkg::ADDR_BITS-1:0]  rsp_granted_address,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_wr_en,
   input  logic [bpa_pkg::ADDR_BITS-1:0]  csr_wr_data
);
   import bpa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;  // alloc: pick word, read it
   localparam logic [2:0] S_SPLIT = 3'd2;  // free: reciprocal multiply
   localparam logic [2:0] S_READ  = 3'd3;  // free: correct quotient, read word
   localparam logic [2:0] S_MOD   = 3'd4;  // modify and write back
   localparam logic [2:0] S_ADDR  = 3'd5;  // alloc: form granted address

   logic [2:0]               state_ff, state_in;
   logic [ADDR_BITS-1:0]     base_ff;
   logic                     kind_ff;
   logic                     oor_ff;
   logic [PAGE_BITS-1:0]     page_ff;
   logic [PAGE_BITS-1:0]     qest_ff, qest_in;
   logic [WIDX_BITS-1:0]     widx_ff, widx_in;
   logic [BIDX_BITS-1:0]     bidx_ff, bidx_in;
   logic [PAGE_BITS-1:0]     wbase_ff, wbase_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic [ADDR_BITS-1:0]     offset;
   logic                     oor_new;
   logic [PROD_BITS-1:0]     split_prod;
   logic [MUL_BITS-1:0]      qmul;
   logic [MUL_BITS-1:0]      rem;
   logic                     rem_fix;
   logic [WIDX_BITS-1:0]     look_widx;
   logic [MUL_BITS-1:0]      look_base;
   logic [BIDX_BITS-1:0]     mod_bit;
   logic [MAP_WORD_BITS-1:0] mod_onehot;
   logic [PAGE_BITS-1:0]     page_sum;
   logic [ADDR_BITS-1:0]     granted;
   logic                     alloc_mod;

   map_req_type              map_req;
   logic [MAP_WORD_BITS-1:0] map_word;
   logic [MAP_WORDS-1:0]     map_summary;

   bpa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .req     (map_req),
      .word    (map_word),
      .summary (map_summary)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // free: offset from base, page number and range check at accept
   assign offset  = req_page_address - base_ff;
   assign oor_new = (offset >> PAGE_SHIFT) >= ADDR_BITS'(NUM_PAGES);

   // page / MAP_WORD_BITS: floor reciprocal estimate, then one correction
   assign split_prod = PROD_BITS'(page_ff) * PROD_BITS'(DIV_RECIP);
   assign qest_in    = split_prod[DIV_SHIFT +: PAGE_BITS];
   assign qmul       = MUL_BITS'(qest_ff) * MUL_BITS'(MAP_WORD_BITS);
   assign rem        = MUL_BITS'(page_ff) - qmul;
   assign rem_fix    = rem >= MUL_BITS'(MAP_WORD_BITS);

   assign look_widx  = ffs_summary(map_summary);
   assign look_base  = MUL_BITS'(look_widx) * MUL_BITS'(MAP_WORD_BITS);

   assign mod_bit    = (kind_ff == KIND_ALLOC) ? ffs_word(map_word) : bidx_ff;
   assign mod_onehot = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << mod_bit;

   assign page_sum   = wbase_ff + PAGE_BITS'(bidx_ff);
   assign granted    = base_ff + (ADDR_BITS'(page_sum) << PAGE_SHIFT);

   assign alloc_mod  = (state_ff == S_MOD) && (kind_ff == KIND_ALLOC);

   always_comb begin
      state_in      = state_ff;
      widx_in       = widx_ff;
      bidx_in       = bidx_ff;
      wbase_in      = wbase_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = ST_OK;
      map_req       = '0;
      map_req.idx   = widx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (req_kind == KIND_ALLOC) ? S_LOOK : S_SPLIT;
         end
         S_LOOK: begin
            if (map_summary == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE_FREE;
               state_in      = S_IDLE;
            end else begin
               widx_in       = look_widx;
               wbase_in      = PAGE_BITS'(look_base);
               map_req.rd_en = 1'b1;
               map_req.idx   = look_widx;
               state_in      = S_MOD;
            end
         end
         S_SPLIT: begin
            if (oor_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OUT_OF_RANGE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            widx_in       = WIDX_BITS'(qest_ff) + WIDX_BITS'(rem_fix);
            bidx_in       = rem_fix ? BIDX_BITS'(rem - MUL_BITS'(MAP_WORD_BITS))
                                    : BIDX_BITS'(rem);
            map_req.rd_en = 1'b1;
            map_req.idx   = widx_in;
            state_in      = S_MOD;
         end
         S_MOD: begin
            map_req.wr_en = 1'b1;
            if (kind_ff == KIND_ALLOC) begin
               map_req.wr_data = map_word & ~mod_onehot;
               bidx_in         = mod_bit;
               state_in        = S_ADDR;
            end else begin
               // double free leaves the bit set and still reports ok
               map_req.wr_data = map_word | mod_onehot;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_ADDR: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = granted;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         oor_ff  <= oor_new;
         page_ff <= offset[PAGE_SHIFT +: PAGE_BITS];
      end
      qest_ff       <= qest_in;
      widx_ff       <= widx_in;
      bidx_ff       <= bidx_in;
      wbase_ff      <= wbase_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // a result only shows once the sequencer is back to idle
   `BPA_ASSERT(a_rsp_when_idle, rsp_valid_ff |-> (state_ff == S_IDLE), "result while busy")
   // map writes only in the modify step, never overlapping a read
   `BPA_ASSERT(a_wr_in_mod, map_req.wr_en |-> state_ff == S_MOD && !map_req.rd_en, "stray write")
   // the summary promised a free page in the chosen word
   `BPA_ASSERT(a_alloc_word_free, alloc_mod |-> map_word != '0, "empty alloc word")
   `BPA_ASSERT(a_accept_busy, accept |=> busy, "accepted item did not raise busy")
   `BPA_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !busy, "activity after reset")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import bpa_pkg::*;

   // Cycles with neither an accepted item nor a result before the run is abandoned.
   // Worst correct case is a drain: the last result, the pause after the drain, a CSR
   // write and a random sender gap.
   localparam int STALL_LIMIT = 1000;
   localparam int MIX_ITEMS   = 1450;
   localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [1:0]           status;
   } grant_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic [ADDR_BITS-1:0] req_page_address;
   logic                 rsp_valid;
   logic [ADDR_BITS-1:0] rsp_granted_address;
   logic [1:0]           rsp_status;
   logic                 csr_wr_en;
   logic [ADDR_BITS-1:0] csr_wr_data;

   // Shadow of the allocator: one bit per page (1 = free), plus the base register.
   bit   [NUM_PAGES-1:0] free_pages;
   logic [ADDR_BITS-1:0] model_base;
   grant_result_type     expected_grants[$];
   // Pages handed out, kept so the stimulus can free real allocations.
   int                   held_pages[$];
   bit                   idle_enable;
   int                   mismatch_count;
   int                   stall_cycles;

   bitmap_page_allocator_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'({$urandom(), $urandom()});
   endfunction

   // Address of page pg under the current base, wrapping at 2^48.
   function automatic logic [ADDR_BITS-1:0] page_addr(input int pg);
      return model_base + (ADDR_BITS'(pg) << PAGE_SHIFT);
   endfunction

   task automatic report_mismatch(input string what, input logic [ADDR_BITS-1:0] got,
                                  input logic [ADDR_BITS-1:0] want);
      $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Work out the result of one accepted item and update the shadow map.
   task automatic predict_grant(input logic kind, input logic [ADDR_BITS-1:0] addr);
      grant_result_type     res;
      logic [ADDR_BITS-1:0] page_num;
      int                   pg;
      res.addr   = '0;
      res.status = ST_OK;
      if (kind == KIND_ALLOC) begin
         // lowest free page wins
         res.status = ST_NONE_FREE;
         pg = -1;
         for (int i = 0; i < NUM_PAGES; i++) begin
            if (free_pages[i]) begin
               pg = i;
               break;
            end
         end
         if (pg >= 0) begin
            free_pages[pg] = 1'b0;
            res.addr       = page_addr(pg);
            res.status     = ST_OK;
            held_pages.push_back(pg);
         end
      end else begin
         // offset wraps mod 2^48; low bits dropped so an unaligned address frees its page
         page_num = (addr - model_base) >> PAGE_SHIFT;
         if (page_num >= ADDR_BITS'(NUM_PAGES))
            res.status = ST_OUT_OF_RANGE;
         else
            free_pages[page_num] = 1'b1;
      end
      expected_grants.push_back(res);
   endtask

   // Present one item and hold it until the block takes it. start stays high on
   // return so back-to-back items see no bubble; a gap lowers it in the accept step.
   task automatic send_request(input logic kind, input logic [ADDR_BITS-1:0] addr);
      if (idle_enable && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_page_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_grant(kind, addr);
   endtask

   // Stop sending and let every outstanding result come back, then a few spare cycles.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Base register writes only happen with the block idle.
   task automatic write_base(input logic [ADDR_BITS-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_base   = value;
   endtask

   // Free one page that was handed out, at a random byte inside it.
   task automatic release_held_page();
      int idx;
      int pg;
      idx = $urandom_range(0, held_pages.size() - 1);
      pg  = held_pages[idx];
      held_pages.delete(idx);
      send_request(KIND_FREE, page_addr(pg) + ADDR_BITS'($urandom_range(0, PAGE_BYTES - 1)));
   endtask

   // Reset base: first allocations, exact/unaligned/double frees, range edges.
   task automatic test_reset_base();
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '1);                 // address ignored for allocate
      send_request(KIND_ALLOC, rand_addr());
      send_request(KIND_FREE, page_addr(1));        // exact page address
      send_request(KIND_ALLOC, '0);                 // page 1 comes back first
      send_request(KIND_FREE, page_addr(2) + 48'hABC);   // unaligned
      send_request(KIND_FREE, page_addr(2));        // double free
      send_request(KIND_FREE, page_addr(0) + 48'hFFF);   // last byte of page 0
      send_request(KIND_FREE, '0);                  // below base
      send_request(KIND_FREE, page_addr(NUM_PAGES));     // one page past the end
      send_request(KIND_FREE, page_addr(NUM_PAGES) - 1); // last byte in range
      send_request(KIND_FREE, '1);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '0);
   endtask

   // Base register at both extremes; map must survive the base change.
   task automatic test_base_extremes();
      write_base('0);
      send_request(KIND_FREE, '0);                  // page 0 at address zero
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, '1);                  // far out of range
      write_base('1);
      send_request(KIND_ALLOC, '0);                 // granted address wraps past 2^48
      send_request(KIND_FREE, page_addr(1));        // wrapped address frees page 1
      send_request(KIND_FREE, '0);                  // offset 1: page 0, wraps into range
      send_request(KIND_FREE, 48'hFFFF_FFFF_FFFE);  // just below base
      send_request(KIND_ALLOC, '0);
   endtask

   // Mostly allocate and free of real pages, with some junk and near-range addresses.
   task automatic test_random_mix();
      int r;
      for (int i = 0; i < MIX_ITEMS; i++) begin
         // new random base every 400 items, no idle gaps for items 400 to 799
         if (i % 400 == 0 && i != 0) write_base(rand_addr());
         idle_enable = !(i >= 400 && i < 800);
         r = $urandom_range(0, 99);
         if (r < 55 || (r < 90 && held_pages.size() == 0))
            send_request(KIND_ALLOC, rand_addr());
         else if (r < 90)
            release_held_page();
         else if (r < 95)
            send_request(KIND_FREE, rand_addr());
         else
            // around the managed window: below base, inside, and past the end
            send_request(KIND_FREE, model_base - ADDR_BITS'(NUM_PAGES * PAGE_BYTES)
                         + ADDR_BITS'($urandom_range(0, 3 * NUM_PAGES * PAGE_BYTES)));
      end
      idle_enable = 1'b1;
   endtask

   // Managed window wrapping through address zero: free and reuse across the wrap.
   task automatic test_wrap_base();
      // page NUM_PAGES/2 lands on address zero
      write_base(ADDR_BITS'(0) - ADDR_BITS'((NUM_PAGES / 2) * PAGE_BYTES));
      send_request(KIND_FREE, '0);
      send_request(KIND_FREE, page_addr(NUM_PAGES - 1));
      repeat (3) send_request(KIND_ALLOC, '0);
      for (int i = 0; i < 120; i++) begin
         if ($urandom_range(0, 2) == 0 || held_pages.size() == 0)
            send_request(KIND_ALLOC, rand_addr());
         else
            release_held_page();
      end
   endtask

   // Result checker: the receiver cannot stall, so every strobe is taken.
   always @(posedge clock) begin
      grant_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("result with no item outstanding", rsp_granted_address, '0);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", ADDR_BITS'(rsp_status), ADDR_BITS'(want.status));
            if (rsp_granted_address !== want.addr)
               report_mismatch("granted_address", rsp_granted_address, want.addr);
         end
      end
   end

   // Watchdog on cycles with no progress on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("** bitmap_page_allocator_core: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= KIND_ALLOC;
      req_page_address <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      idle_enable      = 1'b1;
      free_pages       = '1;
      model_base       = BASE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_base();
      test_base_extremes();
      test_random_mix();
      test_wrap_base();

      drain_results();
      if (mismatch_count == 0) begin
         $display("** bitmap_page_allocator_core: PASSED **");
      end else begin
         $display("** bitmap_page_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule
